// ----- src/murp_pkg.sv -----
// ----------------------------------------------------------------------------
// murp_pkg : shared types and constants for the mixed unit record parser
// Parse phases, character codes and small digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package murp_pkg;

	typedef enum logic [2:0] {
		PH_TYPE   = 3'd0,
		PH_BCOUNT = 3'd1,
		PH_BHI    = 3'd2,
		PH_BLO    = 3'd3,
		PH_AC1    = 3'd4,
		PH_AC2    = 3'd5,
		PH_AC3    = 3'd6,
		PH_ALIST  = 3'd7
	} phase_t;

	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_SOH   = 8'd1;
	localparam logic [7:0] CH_LF    = 8'd10;

	localparam logic [31:0] VALUE_MAX = 32'hFFFF_FFFF;

	localparam logic ITEM_HEADER = 1'b0;
	localparam logic ITEM_VALUE  = 1'b1;
	localparam logic UNIT_BIN    = 1'b0;
	localparam logic UNIT_ASCII  = 1'b1;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// non-digits read as zero
	function automatic logic [3:0] digit_of(input logic [7:0] b);
		logic [7:0] d;
		d = b - CH_ZERO;
		return is_digit(b) ? d[3:0] : 4'd0;
	endfunction

endpackage

`default_nettype wire

// ----- src/mixed_unit_record_parser_top.sv -----
// ----------------------------------------------------------------------------
// mixed_unit_record_parser_top : byte-stream unit parser
// Splits a stream of binary and ASCII-decimal units into one header word per
// unit and one value word per number, flagging bad digits and saturation.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------
//  in      | sink      | in_valid/in_ready | data_byte[7:0]
//  out     | source    | out_valid/out_ready | item_kind, unit_type,
//          |           |                   | unit_count[9:0], parsed_value[31:0],
//          |           |                   | last_of_unit, format_error
//
//  One byte per cycle sustained while the consumer keeps up. A byte is held
//  in the input register, is parsed there, and its word (if any) lands in
//  the output register.
//  The parse stage advances whenever the output register is empty or being
//  drained; a stalled consumer holds the input register and drops in_ready.
//  Reset clears all control and parse state; the parser starts waiting for a
//  type byte. Payload registers are not reset.
//
`default_nettype none

module mixed_unit_record_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input word
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	// output word
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             item_kind,
	output logic             unit_type,
	output logic [9:0]       unit_count,
	output logic [31:0]      parsed_value,
	output logic             last_of_unit,
	output logic             format_error
);

	import murp_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state
	phase_t      phase_q, phase_d;
	logic [7:0]  remain_q, remain_d;
	logic [7:0]  high_q, high_d;
	logic [9:0]  count_q, count_d;
	logic [31:0] value_q, value_d;
	logic        err_q, err_d;

	// result register
	logic        out_valid_q;
	logic        kind_q, type_q, last_q, ferr_q;
	logic [9:0]  ucount_q;
	logic [31:0] pval_q;

	// parse-stage result
	logic        emit;
	logic        r_kind, r_type, r_last, r_err;
	logic [9:0]  r_count;
	logic [31:0] r_value;

	logic        advance;

	// helpers
	logic [3:0]  dig;
	logic        bad_digit;
	logic [35:0] mac;       // value * 10 + digit
	logic [9:0]  hundreds;
	logic [9:0]  tens;
	logic [7:0]  remain_dec;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign dig        = digit_of(byte_s1);
	assign bad_digit  = !is_digit(byte_s1);
	// x10 as x8 + x2, x100 as x64 + x32 + x4
	assign mac        = {1'b0, value_q, 3'b000} + {3'b000, value_q, 1'b0} + {32'd0, dig};
	assign hundreds   = {dig, 6'd0} + {1'b0, dig, 5'd0} + {4'd0, dig, 2'd0};
	assign tens       = {3'd0, dig, 3'd0} + {5'd0, dig, 1'b0};
	assign remain_dec = remain_q - 8'd1;

	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		high_d   = high_q;
		count_d  = count_q;
		value_d  = value_q;
		err_d    = err_q;
		emit     = 1'b0;
		r_kind   = ITEM_HEADER;
		r_type   = UNIT_BIN;
		r_count  = '0;
		r_value  = '0;
		r_last   = 1'b0;
		r_err    = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				count_d = '0;
				err_d   = 1'b0;
				phase_d = (byte_s1 == CH_NUL) ? PH_BCOUNT : PH_AC1;
			end
			PH_BCOUNT: begin
				emit     = 1'b1;
				r_count  = {2'b00, byte_s1};
				remain_d = byte_s1;
				phase_d  = (byte_s1 == CH_NUL) ? PH_TYPE : PH_BHI;
			end
			PH_BHI: begin
				high_d  = byte_s1;
				phase_d = PH_BLO;
			end
			PH_BLO: begin
				emit     = 1'b1;
				r_kind   = ITEM_VALUE;
				r_value  = {16'd0, high_q, byte_s1};
				r_last   = (remain_dec == 8'd0);
				remain_d = remain_dec;
				phase_d  = (remain_dec == 8'd0) ? PH_TYPE : PH_BHI;
			end
			PH_AC1: begin
				count_d = hundreds;
				err_d   = err_q | bad_digit;
				phase_d = PH_AC2;
			end
			PH_AC2: begin
				count_d = count_q + tens;
				err_d   = err_q | bad_digit;
				phase_d = PH_AC3;
			end
			PH_AC3: begin
				emit    = 1'b1;
				r_type  = UNIT_ASCII;
				r_count = count_q + {6'd0, dig};
				r_err   = err_q | bad_digit;
				count_d = count_q + {6'd0, dig};
				err_d   = 1'b0;
				value_d = '0;
				phase_d = PH_ALIST;
			end
			PH_ALIST: begin
				if (byte_s1 == CH_COMMA) begin
					emit    = 1'b1;
					r_kind  = ITEM_VALUE;
					r_type  = UNIT_ASCII;
					r_value = value_q;
					r_err   = err_q;
					value_d = '0;
					err_d   = 1'b0;
				end else if (byte_s1 == CH_NUL || byte_s1 == CH_SOH || byte_s1 == CH_LF) begin
					// list terminator doubles as next type byte
					emit    = 1'b1;
					r_kind  = ITEM_VALUE;
					r_type  = UNIT_ASCII;
					r_value = value_q;
					r_last  = 1'b1;
					r_err   = err_q;
					value_d = '0;
					err_d   = 1'b0;
					count_d = '0;
					phase_d = (byte_s1 == CH_NUL) ? PH_BCOUNT : PH_AC1;
				end else if (mac[35:32] != 4'd0) begin
					value_d = VALUE_MAX;
					err_d   = 1'b1;
				end else begin
					value_d = mac[31:0];
					err_d   = err_q | bad_digit;
				end
			end
			default: phase_d = PH_TYPE;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			remain_q <= '0;
			high_q   <= '0;
			count_q  <= '0;
			value_q  <= '0;
			err_q    <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			high_q   <= high_d;
			count_q  <= count_d;
			value_q  <= value_d;
			err_q    <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q   <= r_kind;
			type_q   <= r_type;
			ucount_q <= r_count;
			pval_q   <= r_value;
			last_q   <= r_last;
			ferr_q   <= r_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign item_kind    = kind_q;
	assign unit_type    = type_q;
	assign unit_count   = ucount_q;
	assign parsed_value = pval_q;
	assign last_of_unit = last_q;
	assign format_error = ferr_q;

endmodule

`default_nettype wire
